// ===== design/weekly_vent_schedule_engine_unit_macros.svh =====
// assertion macros for the weekly vent schedule engine
`ifndef WEEKLY_VENT_SCHEDULE_ENGINE_UNIT_MACROS_SVH
`define WEEKLY_VENT_SCHEDULE_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define WVSE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define WVSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/wvse_pkg.sv =====
// shared types, codes and helpers of the weekly vent schedule engine
package wvse_pkg;

    localparam int SEGS_PER_DAY  = 288;
    localparam int TIME_LIMIT    = 2015;
    localparam int FULL_OPEN     = 255;
    localparam int THRESH_RESET  = 3500;
    localparam int MAX_RESULTS   = 5;
    localparam int CNT_W         = 3;
    localparam int SEG_W         = 11;
    localparam int AMT_W         = 8;
    localparam int STEP_W        = 9;
    localparam int MV_W          = 16;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_BATT  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic              low_battery_flag;
        logic [AMT_W-1:0]  new_position;
        logic [STEP_W-1:0] half_steps;
        logic              turn_ccw;
    } t_move;

    // day holding a weekly segment, 7 for the tail past the last day
    function automatic logic [2:0] seg_day(input logic [SEG_W-1:0] seg);
        logic [2:0] d;
        d = '0;
        for (int k = 1; k < 8; k++) begin
            if (seg >= SEG_W'(k * SEGS_PER_DAY)) begin
                d = 3'(k);
            end
        end
        return d;
    endfunction

    function automatic t_move make_move(input logic [AMT_W-1:0] cur,
                                        input logic [AMT_W-1:0] tgt,
                                        input logic             lowbat);
        t_move m;
        logic [AMT_W-1:0] diff;
        m.turn_ccw = (tgt > cur);
        diff = m.turn_ccw ? (tgt - cur) : (cur - tgt);
        m.half_steps = {diff, 1'b0};
        m.new_position = tgt;
        m.low_battery_flag = lowbat;
        return m;
    endfunction

endpackage

// ===== design/wvse_ram.sv =====
// generic single-port-write, registered-read ram
module wvse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/weekly_vent_schedule_engine_unit.sv =====
// top level of the weekly vent schedule engine
// Keeps a DAYS x SLOTS_PER_DAY weekly schedule in one RAM (time and target)
// with per-slot valid flops cleared by reset, and tracks the vent position and
// a low-battery latch. A battery sample below the threshold places its move in
// the pending register, which passes it to the output register once that is
// free. A tick reads the slots of its day one at a time through the single RAM
// read port (address, then registered data and compare), then releases the
// final move. Moves are held one deep internally so the last one of a run can
// be tagged with tlast; a stalled master side stretches the scan. The next
// item is taken once the previous one has finished, even while its last result
// still sits in the output register.
module weekly_vent_schedule_engine_unit #(
    parameter int DAYS          = 7,
    parameter int SLOTS_PER_DAY = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,     // low_voltage_threshold_mv
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // day_index[2:0] slot_index[5:3] write_time[21:6] write_amount[29:22]
    // tick_segment[40:30] battery_mv[56:41] zero[63:57]
    input  logic [63:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    // move stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // turn_ccw[0] half_steps[9:1] new_position[17:10] low_battery_flag[18] zero[23:19]
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast    // last_of_run
);
    import wvse_pkg::*;

    `include "weekly_vent_schedule_engine_unit_macros.svh"

    localparam int TS = DAYS * SLOTS_PER_DAY;
    localparam int AW = (TS > 1) ? $clog2(TS) : 1;
    localparam int SW = (SLOTS_PER_DAY > 1) ? $clog2(SLOTS_PER_DAY) : 1;
    localparam int RW = SEG_W + AMT_W;

    // request fields
    logic [2:0]       in_day;
    logic [2:0]       in_slot;
    logic [15:0]      in_wtime;
    logic [AMT_W-1:0] in_wamt;
    logic [SEG_W-1:0] in_seg;
    logic [MV_W-1:0]  in_mv;
    t_req             in_req;

    assign in_day   = s_axis_tdata[2:0];
    assign in_slot  = s_axis_tdata[5:3];
    assign in_wtime = s_axis_tdata[21:6];
    assign in_wamt  = s_axis_tdata[29:22];
    assign in_seg   = s_axis_tdata[40:30];
    assign in_mv    = s_axis_tdata[56:41];
    assign in_req   = t_req'(s_axis_tuser);

    // registers
    t_state           r_state, n_state;
    logic [MV_W-1:0]  r_thr, n_thr;
    logic [TS-1:0]    r_valid, n_valid;
    logic [AMT_W-1:0] r_pos, n_pos;
    logic             r_lowbat, n_lowbat;
    logic [SEG_W-1:0] r_seg, n_seg;
    logic [AW-1:0]    r_base, n_base;
    logic [SW-1:0]    r_slot, n_slot;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_move            r_pend, n_pend;
    logic             r_pend_v, n_pend_v;
    t_move            r_out, n_out;
    logic             r_out_last, n_out_last;
    logic             r_out_v, n_out_v;

    // shared decode
    logic             in_acc;
    logic             out_free;
    logic             wr_ok;
    logic [7:0]       wr_lin;
    logic [2:0]       tk_day;
    logic [7:0]       tk_lin;
    logic             tk_go;
    logic             bat_low;
    logic [AW-1:0]    rd_addr;
    logic [RW-1:0]    ram_wdata;
    logic [RW-1:0]    ram_rdata;
    logic             hit;
    logic             slot_last;
    logic             run_full;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_v || m_axis_tready;
    assign wr_ok     = (in_day < 3'(DAYS)) && (5'(in_slot) < 5'(SLOTS_PER_DAY));
    assign wr_lin    = 8'(in_day) * 8'(SLOTS_PER_DAY) + 8'(in_slot);
    assign tk_day    = seg_day(in_seg);
    assign tk_lin    = 8'(tk_day) * 8'(SLOTS_PER_DAY);
    assign tk_go     = (tk_day < 3'(DAYS)) && !r_lowbat;
    assign bat_low   = in_mv < r_thr;
    assign rd_addr   = r_base + AW'(r_slot);
    assign ram_wdata = {in_wtime[SEG_W-1:0], in_wamt};
    assign hit       = r_valid[rd_addr] && (ram_rdata[RW-1:AMT_W] == r_seg);
    assign slot_last = (32'(r_slot) == SLOTS_PER_DAY - 1);
    assign run_full  = (r_cnt + CNT_W'(1)) == CNT_W'(MAX_RESULTS);

    wvse_ram #(
        .WIDTH (RW),
        .DEPTH (TS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && (in_req == REQ_WRITE) && wr_ok),
        .i_waddr (wr_lin[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (r_state == S_READ),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (in_req == REQ_TICK) && tk_go) begin
                    n_state = S_READ;
                end else if (in_acc && (in_req == REQ_BATT) && bat_low) begin
                    n_state = S_FLUSH;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (hit) begin
                    if (!(r_pend_v && !out_free)) begin
                        n_state = (run_full || slot_last) ? S_FLUSH : S_READ;
                    end
                end else if (slot_last) begin
                    n_state = r_pend_v ? S_FLUSH : S_IDLE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath
    always_comb begin
        n_thr      = r_thr;
        n_valid    = r_valid;
        n_pos      = r_pos;
        n_lowbat   = r_lowbat;
        n_seg      = r_seg;
        n_base     = r_base;
        n_slot     = r_slot;
        n_cnt      = r_cnt;
        n_pend     = r_pend;
        n_pend_v   = r_pend_v;
        n_out      = r_out;
        n_out_last = r_out_last;
        n_out_v    = r_out_v && !m_axis_tready;

        if (i_cfg_valid) begin
            n_thr = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (in_req)
                        REQ_WRITE: begin
                            if (wr_ok) begin
                                n_valid[wr_lin[AW-1:0]] = (in_wtime < 16'(TIME_LIMIT));
                            end
                        end
                        REQ_TICK: begin
                            n_seg  = in_seg;
                            n_base = tk_lin[AW-1:0];
                            n_slot = '0;
                            n_cnt  = '0;
                        end
                        REQ_BATT: begin
                            if (bat_low) begin
                                n_lowbat = 1'b1;
                                n_pend   = make_move(r_pos, AMT_W'(FULL_OPEN), 1'b1);
                                n_pend_v = 1'b1;
                                n_pos    = AMT_W'(FULL_OPEN);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CHECK: begin
                if (hit) begin
                    if (!(r_pend_v && !out_free)) begin
                        if (r_pend_v) begin
                            n_out      = r_pend;
                            n_out_last = 1'b0;
                            n_out_v    = 1'b1;
                        end
                        n_pend   = make_move(r_pos, ram_rdata[AMT_W-1:0], r_lowbat);
                        n_pend_v = 1'b1;
                        n_pos    = ram_rdata[AMT_W-1:0];
                        n_cnt    = r_cnt + CNT_W'(1);
                        n_slot   = r_slot + SW'(1);
                    end
                end else begin
                    n_slot = r_slot + SW'(1);
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_out      = r_pend;
                    n_out_last = 1'b1;
                    n_out_v    = 1'b1;
                    n_pend_v   = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_thr    <= MV_W'(THRESH_RESET);
            r_valid  <= '0;
            r_pos    <= AMT_W'(FULL_OPEN);
            r_lowbat <= 1'b0;
            r_cnt    <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_thr    <= n_thr;
            r_valid  <= n_valid;
            r_pos    <= n_pos;
            r_lowbat <= n_lowbat;
            r_cnt    <= n_cnt;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seg      <= n_seg;
        r_base     <= n_base;
        r_slot     <= n_slot;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {5'b0, r_out};
    assign m_axis_tlast  = r_out_last;

    `WVSE_ASSERT_NEXT(a_low_sets_latch, i_clk, i_rst_n,
        in_acc && (in_req == REQ_BATT) && bat_low, r_lowbat && r_pend_v, "battery low not latched")
    `WVSE_ASSERT_NEXT(a_latch_sticky, i_clk, i_rst_n, r_lowbat, r_lowbat, "low-battery latch cleared")
    `WVSE_ASSERT_SAME(a_no_scan_latched, i_clk, i_rst_n,
        (r_state == S_READ) || (r_state == S_CHECK), !r_lowbat, "tick scan while latched")
    `WVSE_ASSERT_SAME(a_run_bounded, i_clk, i_rst_n, r_state != S_IDLE,
        r_cnt <= CNT_W'(MAX_RESULTS), "run exceeds result limit")
    `WVSE_ASSERT_SAME(a_flush_has_move, i_clk, i_rst_n, r_state == S_FLUSH, r_pend_v,
        "flush without pending move")

endmodule
